// ===== hw/rtl/bnb_pkg.sv =====
package bnb_pkg;

	localparam int ACC_W     = 40;
	localparam int OP_W      = 3;
	localparam int IDX_W     = 10;
	localparam int NF_W      = 11;
	localparam int CFG_IDX_W = 1;

	localparam logic [OP_W-1:0] OP_CLEAR      = 3'd0;
	localparam logic [OP_W-1:0] OP_TRAIN_EX   = 3'd1;
	localparam logic [OP_W-1:0] OP_TRAIN_FEAT = 3'd2;
	localparam logic [OP_W-1:0] OP_FINALIZE   = 3'd3;
	localparam logic [OP_W-1:0] OP_SCORE_FEAT = 3'd4;
	localparam logic [OP_W-1:0] OP_SCORE_END  = 3'd5;

	localparam logic [CFG_IDX_W-1:0] REG_NUM_FEATURES = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD    = 1'b1;

	localparam logic [NF_W-1:0] NF_RESET = 11'd1024;

	// ln(2) in Q0.32, rounded
	localparam logic [31:0] LN2_Q32 = 32'd2977044472;

	localparam logic signed [ACC_W-1:0] S40_MAX = {1'b0, {(ACC_W-1){1'b1}}};
	localparam logic signed [ACC_W-1:0] S40_MIN = {1'b1, {(ACC_W-1){1'b0}}};

	function automatic logic signed [ACC_W-1:0] sat_add(
		input logic signed [ACC_W-1:0] a,
		input logic signed [ACC_W-1:0] b
	);
		logic [ACC_W:0] s;
		s = {a[ACC_W-1], a} + {b[ACC_W-1], b};
		if (s[ACC_W] != s[ACC_W-1])
			sat_add = s[ACC_W] ? S40_MIN : S40_MAX;
		else
			sat_add = s[ACC_W-1:0];
	endfunction

	function automatic logic signed [ACC_W-1:0] sat_sub(
		input logic signed [ACC_W-1:0] a,
		input logic signed [ACC_W-1:0] b
	);
		logic [ACC_W:0] s;
		s = {a[ACC_W-1], a} - {b[ACC_W-1], b};
		if (s[ACC_W] != s[ACC_W-1])
			sat_sub = s[ACC_W] ? S40_MIN : S40_MAX;
		else
			sat_sub = s[ACC_W-1:0];
	endfunction

endpackage

// ===== hw/rtl/bnb_ln.sv =====
module bnb_ln import bnb_pkg::*; #(
	parameter int XW        = 21,
	parameter int FRAC_BITS = 16
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [XW-1:0]    x,
	output logic             done,
	output logic [ACC_W-1:0] y
);

	localparam int EW  = $clog2(XW);
	localparam int LGW = EW + FRAC_BITS;
	localparam int KW  = $clog2(FRAC_BITS + 1);
	localparam int PW  = LGW + 32;
	localparam logic [PW:0] HALF = (PW+1)'(1) << 31;

	typedef enum logic [2:0] {L_IDLE, L_NORM, L_SQ, L_MUL, L_RND} lstate_t;

	lstate_t        state_q;
	logic [XW-1:0]  n_q;
	logic [EW-1:0]  e_q;
	logic [30:0]    m_q;
	logic [LGW-1:0] lg_q;
	logic [KW-1:0]  k_q;
	logic [PW-1:0]  p_q;

	logic [XW+30:0] nx;
	logic [30:0]    mant;
	logic [61:0]    sq;
	logic [31:0]    sh;
	logic [PW:0]    rs;

	always_comb begin
		nx   = {n_q, 31'b0};
		mant = nx[XW+30 -: 31];
		sq   = 62'(m_q) * 62'(m_q);
		sh   = sq[61:30];
		rs   = {1'b0, p_q} + HALF;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= L_IDLE;
			done    <= 1'b0;
			y       <= '0;
			n_q     <= '0;
			e_q     <= '0;
			m_q     <= '0;
			lg_q    <= '0;
			k_q     <= '0;
			p_q     <= '0;
		end else begin
			done <= (state_q == L_RND);
			unique case (state_q)
				L_IDLE: begin
					if (start) begin
						n_q     <= x;
						e_q     <= EW'(XW - 1);
						state_q <= L_NORM;
					end
				end
				L_NORM: begin
					// one bit of normalization a cycle
					if (n_q[XW-1] || e_q == '0) begin
						m_q     <= mant;
						lg_q    <= LGW'(e_q);
						k_q     <= '0;
						state_q <= L_SQ;
					end else begin
						n_q <= n_q << 1;
						e_q <= e_q - 1'b1;
					end
				end
				L_SQ: begin
					if (sh[31]) begin
						m_q  <= sh[31:1];
						lg_q <= {lg_q[LGW-2:0], 1'b1};
					end else begin
						m_q  <= sh[30:0];
						lg_q <= {lg_q[LGW-2:0], 1'b0};
					end
					k_q <= k_q + 1'b1;
					if (k_q == KW'(FRAC_BITS - 1))
						state_q <= L_MUL;
				end
				L_MUL: begin
					p_q     <= PW'(lg_q) * PW'(LN2_Q32);
					state_q <= L_RND;
				end
				L_RND: begin
					y       <= ACC_W'(rs[PW:32]);
					state_q <= L_IDLE;
				end
				default: state_q <= L_IDLE;
			endcase
		end
	end

endmodule

// ===== hw/rtl/bernoulli_naive_bayes_engine.sv =====
// bernoulli naive bayes engine, binary classes, laplace smoothing, q.FRAC_BITS weights
//
// command channel: a word (op, label, feature_index) is taken on a clock edge with
// start high and busy low. ops: clear, train example start, train feature,
// finalize, score feature, score end; unused op codes are dropped.
// result channel: only score end makes a word. score, prediction and range_error
// sit on the ports for the one cycle that done is high; done is registered
// from S_EMIT. the receiver cannot stall, so nothing here waits on it.
// config: cfg_we writes num_features (index 0) or threshold (index 1) at once.
// commands: train example start completes on the accepting edge; train feature
// is one count memory read-modify-write, score feature one weight memory read
// and accumulate, and score end one emit step.
// finalize runs the shared log unit five times, then four times per in-use
// feature, and walks every one of the MAX_FEATURES entries; the log unit sets
// the finalize time.
// clear walks MAX_FEATURES entries, one a cycle, while busy is high.
// after reset the same clearing pass runs before the first word is taken;
// registers reset, weight memory content is only trusted once the known bit
// of the entry is set.
module bernoulli_naive_bayes_engine import bnb_pkg::*; #(
	parameter int MAX_FEATURES = 1024,
	parameter int COUNT_BITS   = 20,
	parameter int FRAC_BITS    = 16
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	input  logic [OP_W-1:0]         op,
	input  logic                    label,
	input  logic [IDX_W-1:0]        feature_index,
	input  logic                    cfg_we,
	input  logic [CFG_IDX_W-1:0]    cfg_index,
	input  logic [ACC_W-1:0]        cfg_data,
	output logic                    busy,
	output logic                    done,
	output logic signed [ACC_W-1:0] score,
	output logic                    prediction,
	output logic                    range_error
);

	localparam int AW = $clog2(MAX_FEATURES);
	localparam int CB = COUNT_BITS;
	localparam int XW = CB + 1;          // widest log argument: pos + neg
	localparam int NW = CB + 2;          // signed numerators
	localparam int CW = 2 * CB;          // {pos count, neg count}
	localparam int WW = ACC_W + 1;       // {known, weight}
	localparam logic [AW-1:0] LAST    = AW'(MAX_FEATURES - 1);
	localparam logic [CB-1:0] CNT_MAX = {CB{1'b1}};

	typedef enum logic [3:0] {
		S_CLR, S_IDLE, S_TR, S_SC, S_EMIT,
		S_FI_LN, S_FI_BIAS, S_FE_RD, S_FE_CHK, S_FE_LN, S_FE_A, S_FE_B
	} state_t;

	// state memories
	logic [CW-1:0] cnt_mem [MAX_FEATURES];
	logic [WW-1:0] wt_mem  [MAX_FEATURES];

	state_t                  state_q;
	logic [NF_W-1:0]         nf_q;
	logic signed [ACC_W-1:0] thr_q;
	logic [AW-1:0]           ptr_q;
	logic [AW-1:0]           idx_q;
	logic                    lbl_q;
	logic                    err_q;
	logic [CB-1:0]           pos_q;
	logic [CB-1:0]           neg_q;
	logic signed [ACC_W-1:0] bias_q;
	logic signed [ACC_W-1:0] acc_q;
	logic signed [ACC_W-1:0] sum_q;
	logic [ACC_W-1:0]        ltot_q;
	logic [ACC_W-1:0]        lpd_q;
	logic [ACC_W-1:0]        lnd_q;
	logic signed [ACC_W-1:0] rp_q;
	logic signed [ACC_W-1:0] rn_q;
	logic signed [ACC_W-1:0] r_q [4];
	logic signed [NW-1:0]    a_q [4];
	logic signed [ACC_W-1:0] t1_q;
	logic signed [ACC_W-1:0] t2_q;
	logic signed [ACC_W-1:0] t3_q;
	logic [2:0]              jc_q;
	logic                    ln_run_q;
	logic                    done_q;
	logic signed [ACC_W-1:0] score_q;
	logic                    pred_q;
	logic                    rerr_q;

	logic [CW-1:0] cnt_rd_q;
	logic [WW-1:0] wt_rd_q;

	// memory port controls
	logic          cnt_re, cnt_we, wt_re, wt_we;
	logic [AW-1:0] cnt_raddr, cnt_waddr, wt_waddr;
	logic [CW-1:0] cnt_wdata;
	logic [WW-1:0] wt_wdata;

	logic                    acc_in;
	logic [31:0]             idx32;
	logic                    in_range;
	logic [AW-1:0]           addr_in;
	logic                    in_use;
	logic [CB-1:0]           rd_pos, rd_neg;
	logic [CB-1:0]           inc_pos, inc_neg;
	logic signed [NW-1:0]    a0, a1, a2, a3;
	logic signed [NW-1:0]    a_cur;
	logic [XW-1:0]           tot;
	logic                    ln_start;
	logic [XW-1:0]           ln_x;
	logic                    ln_done;
	logic [ACC_W-1:0]        ln_y;
	logic [ACC_W-1:0]        ln_den;
	logic signed [ACC_W-1:0] r_new;
	logic signed [ACC_W-1:0] weight;

	assign busy        = (state_q != S_IDLE);
	assign done        = done_q;
	assign score       = score_q;
	assign prediction  = pred_q;
	assign range_error = rerr_q;

	always_comb begin
		acc_in   = start && !busy;
		idx32    = 32'(feature_index);
		in_range = (idx32 < 32'(nf_q)) && (idx32 < 32'(MAX_FEATURES));
		addr_in  = idx32[AW-1:0];
		in_use   = 32'(ptr_q) < 32'(nf_q);
		rd_pos   = cnt_rd_q[CW-1:CB];
		rd_neg   = cnt_rd_q[CB-1:0];
		inc_pos  = (rd_pos == CNT_MAX) ? rd_pos : rd_pos + 1'b1;
		inc_neg  = (rd_neg == CNT_MAX) ? rd_neg : rd_neg + 1'b1;
		// smoothed numerators; can go non-positive when counts disagree
		a0       = NW'(pos_q) - NW'(rd_pos) + NW'(1);
		a1       = NW'(rd_pos) + NW'(1);
		a2       = NW'(neg_q) - NW'(rd_neg) + NW'(1);
		a3       = NW'(rd_neg) + NW'(1);
		a_cur    = a_q[jc_q[1:0]];
		tot      = XW'(pos_q) + XW'(neg_q);
		weight   = sat_sub(t1_q, t2_q);
	end

	// log unit argument for the current job
	always_comb begin
		ln_x   = a_cur[XW-1:0];
		ln_den = jc_q[1] ? lnd_q : lpd_q;
		if (state_q == S_FI_LN) begin
			case (jc_q)
				3'd0:    ln_x = tot;
				3'd1:    ln_x = XW'(pos_q);
				3'd2:    ln_x = XW'(neg_q);
				3'd3:    ln_x = XW'(pos_q) + XW'(2);
				default: ln_x = XW'(neg_q) + XW'(2);
			endcase
		end
		ln_start = (state_q == S_FI_LN || state_q == S_FE_LN) && !ln_run_q;
		// log of zero or less saturates low
		r_new = (!a_cur[NW-1] && a_cur != '0) ? ACC_W'(ln_y - ln_den) : S40_MIN;
	end

	// memory port muxing
	always_comb begin
		cnt_re    = (acc_in && op == OP_TRAIN_FEAT && in_range) || state_q == S_FE_RD;
		cnt_raddr = (state_q == S_FE_RD) ? ptr_q : addr_in;
		wt_re     = acc_in && op == OP_SCORE_FEAT && in_range;
		cnt_we    = 1'b0;
		cnt_waddr = ptr_q;
		cnt_wdata = '0;
		wt_we     = 1'b0;
		wt_waddr  = ptr_q;
		wt_wdata  = '0;
		case (state_q)
			S_CLR: begin
				cnt_we = 1'b1;
				wt_we  = 1'b1;
			end
			S_TR: begin
				cnt_we    = 1'b1;
				cnt_waddr = idx_q;
				cnt_wdata = lbl_q ? {inc_pos, rd_neg} : {rd_pos, inc_neg};
			end
			S_FE_CHK: wt_we = !in_use;
			S_FE_B: begin
				wt_we    = 1'b1;
				wt_wdata = {(rd_pos != '0) && (rd_neg != '0), weight};
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (cnt_we)
			cnt_mem[cnt_waddr] <= cnt_wdata;
		if (cnt_re)
			cnt_rd_q <= cnt_mem[cnt_raddr];
	end

	always_ff @(posedge clk) begin
		if (wt_we)
			wt_mem[wt_waddr] <= wt_wdata;
		if (wt_re)
			wt_rd_q <= wt_mem[addr_in];
	end

	bnb_ln #(
		.XW        (XW),
		.FRAC_BITS (FRAC_BITS)
	) u_ln (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (ln_start),
		.x      (ln_x),
		.done   (ln_done),
		.y      (ln_y)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_CLR;
			nf_q     <= NF_RESET;
			thr_q    <= '0;
			ptr_q    <= '0;
			idx_q    <= '0;
			lbl_q    <= 1'b0;
			err_q    <= 1'b0;
			pos_q    <= '0;
			neg_q    <= '0;
			bias_q   <= '0;
			acc_q    <= '0;
			sum_q    <= '0;
			ltot_q   <= '0;
			lpd_q    <= '0;
			lnd_q    <= '0;
			rp_q     <= '0;
			rn_q     <= '0;
			r_q      <= '{default: '0};
			a_q      <= '{default: '0};
			t1_q     <= '0;
			t2_q     <= '0;
			t3_q     <= '0;
			jc_q     <= '0;
			ln_run_q <= 1'b0;
			done_q   <= 1'b0;
			score_q  <= '0;
			pred_q   <= 1'b0;
			rerr_q   <= 1'b0;
		end else begin
			done_q <= (state_q == S_EMIT);

			if (cfg_we) begin
				unique case (cfg_index)
					REG_NUM_FEATURES: nf_q  <= cfg_data[NF_W-1:0];
					REG_THRESHOLD:    thr_q <= cfg_data;
					default: ;
				endcase
			end

			unique case (state_q)
				S_CLR: begin
					ptr_q <= ptr_q + 1'b1;
					if (ptr_q == LAST)
						state_q <= S_IDLE;
				end
				S_IDLE: begin
					if (acc_in) begin
						unique case (op)
							OP_CLEAR: begin
								pos_q   <= '0;
								neg_q   <= '0;
								bias_q  <= '0;
								acc_q   <= '0;
								lbl_q   <= 1'b0;
								err_q   <= 1'b0;
								ptr_q   <= '0;
								state_q <= S_CLR;
							end
							OP_TRAIN_EX: begin
								lbl_q <= label;
								if (label)
									pos_q <= (pos_q == CNT_MAX) ? pos_q : pos_q + 1'b1;
								else
									neg_q <= (neg_q == CNT_MAX) ? neg_q : neg_q + 1'b1;
							end
							OP_TRAIN_FEAT: begin
								if (!in_range) begin
									err_q <= 1'b1;
								end else begin
									idx_q   <= addr_in;
									state_q <= S_TR;
								end
							end
							OP_FINALIZE: begin
								jc_q     <= '0;
								ln_run_q <= 1'b0;
								state_q  <= S_FI_LN;
							end
							OP_SCORE_FEAT: begin
								if (!in_range)
									err_q <= 1'b1;
								else
									state_q <= S_SC;
							end
							OP_SCORE_END: begin
								sum_q   <= sat_add(bias_q, acc_q);
								acc_q   <= '0;
								state_q <= S_EMIT;
							end
							default: ;
						endcase
					end
				end
				S_TR: state_q <= S_IDLE;
				S_SC: begin
					if (wt_rd_q[ACC_W])
						acc_q <= sat_add(acc_q, wt_rd_q[ACC_W-1:0]);
					state_q <= S_IDLE;
				end
				S_EMIT: begin
					score_q <= sum_q;
					pred_q  <= sum_q > thr_q;
					rerr_q  <= err_q;
					state_q <= S_IDLE;
				end
				S_FI_LN: begin
					// ln(tot), ratios for the prior, then both smoothing denominators
					if (!ln_run_q) begin
						ln_run_q <= 1'b1;
					end else if (ln_done) begin
						ln_run_q <= 1'b0;
						jc_q     <= jc_q + 1'b1;
						case (jc_q)
							3'd0:    ltot_q <= ln_y;
							3'd1:    rp_q <= (pos_q != '0) ? ACC_W'(ln_y - ltot_q) : S40_MIN;
							3'd2:    rn_q <= (neg_q != '0) ? ACC_W'(ln_y - ltot_q) : S40_MIN;
							3'd3:    lpd_q <= ln_y;
							default: begin
								lnd_q   <= ln_y;
								state_q <= S_FI_BIAS;
							end
						endcase
					end
				end
				S_FI_BIAS: begin
					bias_q  <= sat_sub(rp_q, rn_q);
					ptr_q   <= '0;
					state_q <= S_FE_RD;
				end
				S_FE_RD: state_q <= S_FE_CHK;
				S_FE_CHK: begin
					if (in_use) begin
						a_q[0]   <= a0;
						a_q[1]   <= a1;
						a_q[2]   <= a2;
						a_q[3]   <= a3;
						jc_q     <= '0;
						ln_run_q <= 1'b0;
						state_q  <= S_FE_LN;
					end else if (ptr_q == LAST) begin
						acc_q   <= '0;
						state_q <= S_IDLE;
					end else begin
						ptr_q   <= ptr_q + 1'b1;
						state_q <= S_FE_RD;
					end
				end
				S_FE_LN: begin
					// jobs: p0 pos, p1 pos, p0 neg, p1 neg
					if (!ln_run_q) begin
						ln_run_q <= 1'b1;
					end else if (ln_done) begin
						ln_run_q        <= 1'b0;
						r_q[jc_q[1:0]]  <= r_new;
						jc_q            <= jc_q + 1'b1;
						if (jc_q == 3'd3)
							state_q <= S_FE_A;
					end
				end
				S_FE_A: begin
					t1_q    <= sat_sub(r_q[1], r_q[0]);
					t2_q    <= sat_sub(r_q[3], r_q[2]);
					t3_q    <= sat_sub(r_q[0], r_q[2]);
					state_q <= S_FE_B;
				end
				S_FE_B: begin
					bias_q <= sat_add(bias_q, t3_q);
					if (ptr_q == LAST) begin
						acc_q   <= '0;
						state_q <= S_IDLE;
					end else begin
						ptr_q   <= ptr_q + 1'b1;
						state_q <= S_FE_RD;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

// ===== hw/rtl/bnb_chk.sv =====
module bnb_chk import bnb_pkg::*; (
	input logic            clk,
	input logic            arst_n,
	input logic            start,
	input logic            busy,
	input logic            done,
	input logic [OP_W-1:0] op
);

	// a result word is a single-cycle strobe
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("done held for more than one cycle");

	// score end produces its word through the S_EMIT state and the done register
	a_end_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && op == OP_SCORE_END) |-> ##2 done)
		else $error("score end word missing");

	// training example start never leaves the block busy
	a_ex_fast: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && op == OP_TRAIN_EX) |=> !busy)
		else $error("train example start left block busy");

	// a result only follows work in progress
	a_done_src: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy))
		else $error("done without preceding work");

endmodule

bind bernoulli_naive_bayes_engine bnb_chk u_bnb_chk (.*);

// ===== tb/sv/bnb_checker.sv =====
`timescale 1ns / 1ps

// watches command, config and result ports, predicts each score word and compares
module bnb_checker import bnb_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	input  logic                    busy,
	input  logic [OP_W-1:0]         op,
	input  logic                    label,
	input  logic [IDX_W-1:0]        feature_index,
	input  logic                    cfg_we,
	input  logic [CFG_IDX_W-1:0]    cfg_index,
	input  logic [ACC_W-1:0]        cfg_data,
	input  logic                    done,
	input  logic signed [ACC_W-1:0] score,
	input  logic                    prediction,
	input  logic                    range_error,
	output int                      errors,
	output int                      pending
);

	localparam int          N_FEAT  = 1024;
	localparam int          LOG_FRAC = 16;
	localparam int unsigned CNT_SAT = (1 << 20) - 1;
	localparam longint      MAX40   = 64'sd549755813887;
	localparam longint      MIN40   = -64'sd549755813888;

	typedef struct {
		longint score;
		logic   prediction;
		logic   range_error;
	} score_word_t;

	score_word_t expected_scores[$];

	int unsigned pos_hits [N_FEAT];
	int unsigned neg_hits [N_FEAT];
	longint      weight   [N_FEAT];
	bit          known    [N_FEAT];
	int unsigned pos_examples, neg_examples;
	longint      bias, acc, thr;
	bit          cur_label, err_flag;
	logic [NF_W-1:0] nf;

	function automatic longint clip40(input longint v);
		if (v > MAX40) return MAX40;
		if (v < MIN40) return MIN40;
		return v;
	endfunction

	function automatic int unsigned bump(input int unsigned c);
		return (c < CNT_SAT) ? c + 1 : c;
	endfunction

	// natural log in Q.16 via bit-serial log2 of a Q1.30 mantissa
	function automatic longint ln_fixed(input longint unsigned x);
		int unsigned     e;
		longint unsigned t, y, lg;
		e = 0;
		t = x;
		while (t > 1) begin
			t >>= 1;
			e++;
		end
		if (e <= 30) y = x << (30 - e);
		else y = x >> (e - 30);
		lg = e;
		for (int k = 0; k < LOG_FRAC; k++) begin
			y = (y * y) >> 30;
			lg <<= 1;
			if (y >= (64'd2 << 30)) begin
				y >>= 1;
				lg |= 1;
			end
		end
		return longint'((lg * 64'd2977044472 + (64'd1 << 31)) >> 32);
	endfunction

	function automatic longint ln_of_ratio(input longint num, input longint unsigned den);
		if (num <= 0 || den == 0) return MIN40;
		return clip40(ln_fixed(num) - ln_fixed(den));
	endfunction

	function automatic int unsigned in_use();
		return (nf < N_FEAT) ? nf : N_FEAT;
	endfunction

	function automatic void clear_model();
		for (int i = 0; i < N_FEAT; i++) begin
			pos_hits[i] = 0;
			neg_hits[i] = 0;
			known[i]    = 0;
		end
		pos_examples = 0;
		neg_examples = 0;
		bias         = 0;
		acc          = 0;
		cur_label    = 0;
		err_flag     = 0;
	endfunction

	function automatic void build_weights();
		longint unsigned pos, neg, tot;
		longint          b, p0p, p1p, p0n, p1n;
		int unsigned     lim;
		pos = pos_examples;
		neg = neg_examples;
		tot = pos + neg;
		lim = in_use();
		b = clip40(ln_of_ratio(pos, tot) - ln_of_ratio(neg, tot));
		for (int i = 0; i < N_FEAT; i++) begin
			if (i >= lim) begin
				known[i] = 0;
			end else begin
				p0p = ln_of_ratio(longint'(pos) - pos_hits[i] + 1, pos + 2);
				p1p = ln_of_ratio(longint'(pos_hits[i]) + 1, pos + 2);
				p0n = ln_of_ratio(longint'(neg) - neg_hits[i] + 1, neg + 2);
				p1n = ln_of_ratio(longint'(neg_hits[i]) + 1, neg + 2);
				weight[i] = clip40(clip40(p1p - p0p) - clip40(p1n - p0n));
				known[i]  = (pos_hits[i] > 0) && (neg_hits[i] > 0);
				b = clip40(b + clip40(p0p - p0n));
			end
		end
		bias = b;
		acc  = 0;
	endfunction

	function automatic void apply_word(input logic [OP_W-1:0] o, input logic l,
			input logic [IDX_W-1:0] idx);
		score_word_t w;
		bit          ok;
		longint      s;
		ok = idx < in_use();
		case (o)
			OP_CLEAR: clear_model();
			OP_TRAIN_EX: begin
				cur_label = l;
				if (l) pos_examples = bump(pos_examples);
				else neg_examples = bump(neg_examples);
			end
			OP_TRAIN_FEAT: begin
				if (!ok) err_flag = 1;
				else if (cur_label) pos_hits[idx] = bump(pos_hits[idx]);
				else neg_hits[idx] = bump(neg_hits[idx]);
			end
			OP_FINALIZE: build_weights();
			OP_SCORE_FEAT: begin
				if (!ok) err_flag = 1;
				else if (known[idx]) acc = clip40(acc + weight[idx]);
			end
			OP_SCORE_END: begin
				s = clip40(bias + acc);
				acc = 0;
				w.score       = s;
				w.prediction  = s > thr;
				w.range_error = err_flag;
				expected_scores = {expected_scores, w};
			end
			default: ;
		endcase
	endfunction

	always @(posedge clk or negedge arst_n) begin
		score_word_t w;
		if (!arst_n) begin
			clear_model();
			for (int i = 0; i < N_FEAT; i++) weight[i] = 0;
			nf      = NF_RESET;
			thr     = 0;
			errors  = 0;
			pending <= 0;
			expected_scores.delete();
		end else begin
			// result first: an edge can retire an older word and accept a new one
			if (done) begin
				if (expected_scores.size() == 0) begin
					$error("score word with nothing expected");
					errors++;
				end else begin
					w = expected_scores.pop_front();
					if (score !== w.score[ACC_W-1:0]) begin
						$error("score: expected %0d actual %0d", w.score, score);
						errors++;
					end
					if (prediction !== w.prediction) begin
						$error("prediction: expected %0d actual %0d", w.prediction,
							prediction);
						errors++;
					end
					if (range_error !== w.range_error) begin
						$error("range_error: expected %0d actual %0d", w.range_error,
							range_error);
						errors++;
					end
				end
			end
			if (cfg_we) begin
				if (cfg_index == REG_NUM_FEATURES) nf = cfg_data[NF_W-1:0];
				else if (cfg_index == REG_THRESHOLD) thr = longint'(signed'(cfg_data));
			end
			if (start && !busy) apply_word(op, label, feature_index);
			pending <= expected_scores.size();
		end
	end

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
	import bnb_pkg::*;

	// cycles with no word, result or register write before giving up;
	// a full-size weight build is roughly 4100 logs
	localparam int STALL_LIMIT = 600000;
	localparam int PHASE_WORDS = 450;

	logic                    clk = 0;
	logic                    arst_n = 0;
	logic                    start = 0;
	logic [OP_W-1:0]         op = OP_CLEAR;
	logic                    label = 0;
	logic [IDX_W-1:0]        feature_index = 0;
	logic                    cfg_we = 0;
	logic [CFG_IDX_W-1:0]    cfg_index = REG_NUM_FEATURES;
	logic [ACC_W-1:0]        cfg_data = 0;
	logic                    busy, done, prediction, range_error;
	logic signed [ACC_W-1:0] score;

	int errors, pending;
	int idle_pct;        // chance in a hundred that the sender holds a word back
	int words_sent;
	int nf_cur;          // in-use feature count as the block sees it
	int quiet_cycles = 0;

	always #6 clk = ~clk;

	bernoulli_naive_bayes_engine DUT (
		.clk(clk), .arst_n(arst_n), .start(start), .op(op), .label(label),
		.feature_index(feature_index), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .busy(busy), .done(done), .score(score),
		.prediction(prediction), .range_error(range_error)
	);

	bnb_checker u_checker (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .op(op),
		.label(label), .feature_index(feature_index), .cfg_we(cfg_we),
		.cfg_index(cfg_index), .cfg_data(cfg_data), .done(done), .score(score),
		.prediction(prediction), .range_error(range_error), .errors(errors),
		.pending(pending)
	);

	// watchdog: an accepted word, a result or a register write resets the count
	always @(posedge clk) begin
		if ((start && !busy) || done || cfg_we) quiet_cycles <= 0;
		else quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles > STALL_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	// one command word; start stays high after acceptance unless the next word idles
	task automatic send(input logic [OP_W-1:0] o, input logic l, input logic [IDX_W-1:0] i);
		while ($urandom_range(99) < idle_pct) begin
			start <= 0;
			@(posedge clk);
		end
		start         <= 1;
		op            <= o;
		label         <= l;
		feature_index <= i;
		@(posedge clk);
		while (busy) @(posedge clk);
		words_sent++;
	endtask

	// register write only with the block drained; a finalize can still be
	// running after the last score word, so give busy time to rise
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [ACC_W-1:0] d);
		start <= 0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (4) @(posedge clk);
		while (busy) @(posedge clk);
		cfg_we    <= 1;
		cfg_index <= idx;
		cfg_data  <= d;
		@(posedge clk);
		cfg_we <= 0;
		if (idx == REG_NUM_FEATURES) nf_cur = (d[NF_W-1:0] < 1024) ? d[NF_W-1:0] : 1024;
	endtask

	// mostly legal indices, some past the in-use range
	function automatic logic [IDX_W-1:0] pick_feature();
		if (nf_cur > 0 && $urandom_range(9) != 0) return IDX_W'($urandom_range(nf_cur - 1));
		return IDX_W'($urandom_range(1023));
	endfunction

	function automatic logic [ACC_W-1:0] pick_threshold();
		case ($urandom_range(5))
			0: return {1'b0, {(ACC_W-1){1'b1}}};
			1: return {1'b1, {(ACC_W-1){1'b0}}};
			2: return ACC_W'({$urandom, $urandom});
			default: return ACC_W'(longint'($urandom_range(4000000)) - 2000000);
		endcase
	endfunction

	function automatic logic rand_bit();
		return 1'($urandom_range(1));
	endfunction

	function automatic logic [IDX_W-1:0] rand_idx();
		return IDX_W'($urandom_range(1023));
	endfunction

	// after optional register writes and clear, train a few examples, usually build weights, then score a few queries
	task automatic random_round();
		int n_ex, n_q;
		if ($urandom_range(3) == 0) write_reg(REG_NUM_FEATURES, ACC_W'($urandom_range(24)));
		if ($urandom_range(3) == 0) write_reg(REG_THRESHOLD, pick_threshold());
		if ($urandom_range(19) == 0) send(OP_CLEAR, rand_bit(), rand_idx());
		n_ex = $urandom_range(1, 6);
		repeat (n_ex) begin
			send(OP_TRAIN_EX, rand_bit(), rand_idx());
			repeat ($urandom_range(4)) send(OP_TRAIN_FEAT, rand_bit(), pick_feature());
			// noise: any op code, unused ones included
			if ($urandom_range(9) == 0)
				send(OP_W'($urandom_range(7)), rand_bit(), rand_idx());
		end
		if ($urandom_range(7) != 0) send(OP_FINALIZE, rand_bit(), rand_idx());
		n_q = $urandom_range(1, 4);
		repeat (n_q) begin
			repeat ($urandom_range(5)) send(OP_SCORE_FEAT, rand_bit(), pick_feature());
			send(OP_SCORE_END, rand_bit(), rand_idx());
		end
	endtask

	initial begin
		idle_pct     = 20;
		words_sent   = 0;
		nf_cur       = 1024;
		repeat (10) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// score with an empty model, unused op codes
		send(OP_SCORE_END, 1'b1, 10'h3ff);
		send(3'd6, 1'b1, 10'h155);
		send(3'd7, 1'b0, 10'h2aa);

		// full-size build with the feature count register above the memory depth
		write_reg(REG_NUM_FEATURES, ACC_W'(11'h7ff));
		write_reg(REG_THRESHOLD, {1'b0, {(ACC_W-1){1'b1}}});
		send(OP_TRAIN_EX, 1'b1, 10'd0);
		send(OP_TRAIN_FEAT, 1'b0, 10'd0);
		send(OP_TRAIN_FEAT, 1'b1, 10'h3ff);
		send(OP_TRAIN_EX, 1'b0, 10'h3ff);
		send(OP_TRAIN_FEAT, 1'b0, 10'd0);
		send(OP_TRAIN_FEAT, 1'b1, 10'd5);
		send(OP_FINALIZE, 1'b0, 10'd0);
		send(OP_SCORE_FEAT, 1'b0, 10'd0);
		send(OP_SCORE_FEAT, 1'b1, 10'h3ff);
		send(OP_SCORE_FEAT, 1'b0, 10'd0);
		send(OP_SCORE_END, 1'b0, 10'd0);

		// nothing in use: every index is out of range, build computes no weights
		write_reg(REG_NUM_FEATURES, ACC_W'(0));
		write_reg(REG_THRESHOLD, {1'b1, {(ACC_W-1){1'b0}}});
		send(OP_TRAIN_FEAT, 1'b0, 10'd0);
		send(OP_FINALIZE, 1'b1, 10'h3ff);
		send(OP_SCORE_FEAT, 1'b1, 10'd0);
		send(OP_SCORE_END, 1'b1, 10'd0);

		// empty negative class gives log of zero; clear drops the error flag
		send(OP_CLEAR, 1'b1, 10'h3ff);
		write_reg(REG_NUM_FEATURES, ACC_W'(3));
		send(OP_TRAIN_EX, 1'b1, 10'd0);
		send(OP_TRAIN_FEAT, 1'b0, 10'd2);
		send(OP_TRAIN_FEAT, 1'b1, 10'd3);
		send(OP_FINALIZE, 1'b0, 10'd0);
		send(OP_SCORE_FEAT, 1'b0, 10'd2);
		send(OP_SCORE_END, 1'b0, 10'd0);

		// random phases: sender idles 20%, then 69%, then never
		for (int ph = 0; ph < 3; ph++) begin
			idle_pct = (ph == 0) ? 20 : (ph == 1) ? 69 : 0;
			write_reg(REG_NUM_FEATURES,
				(ph == 0) ? ACC_W'(1) : ACC_W'($urandom_range(2, 24)));
			write_reg(REG_THRESHOLD, pick_threshold());
			words_sent = 0;
			while (words_sent < PHASE_WORDS) random_round();
		end

		start <= 0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (errors == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule
